### design/motor_rail_fault_latch_unit_assert.svh
// assertion macros for the motor rail fault latch unit
`ifndef MOTOR_RAIL_FAULT_LATCH_UNIT_ASSERT_SVH
`define MOTOR_RAIL_FAULT_LATCH_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MRFL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MRFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mrfl_pkg.sv
// types and constants for the motor rail fault latch unit
package mrfl_pkg;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_SETTLE_WINDOW  = 1'b0,
    CFG_FAULT_DEBOUNCE = 1'b1
  } cfg_reg_t;

  // trip cause codes
  localparam logic [1:0] CAUSE_NONE  = 2'd0;
  localparam logic [1:0] CAUSE_ESTOP = 2'd1;
  localparam logic [1:0] CAUSE_PGOOD = 2'd2;

  // register reset values
  localparam logic [15:0] SETTLE_WINDOW_RESET  = 16'd182;
  localparam logic [15:0] FAULT_DEBOUNCE_RESET = 16'd50;

  typedef struct packed {
    logic        estop_active;
    logic        motor_power_good;
    logic        system_powered;
    logic        motor_enabled_now;
    logic [31:0] time_ms;
    logic        operator_clear;
  } item_t;

  typedef struct packed {
    logic       motor_off_cmd;
    logic       motor_on_cmd;
    logic       fan_full_cmd;
    logic [1:0] trip_cause;
    logic       trip_latched;
  } result_t;

endpackage

### design/motor_rail_fault_latch_unit.sv
// motor rail fault latch: trip latch, settle window and power-good debounce
// result beats are registered on the output register; throughput: one item per cycle while
// not stalled by a held result, set by the single registered update of latch and monitor state
// a new item is taken while the previous result is being taken in the same cycle
// reset (synchronous, active high) clears latch and monitor state, empties the output register
// and loads the default settle window and debounce times
module motor_rail_fault_latch_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  mrfl_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output mrfl_pkg::result_t   result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  mrfl_pkg::cfg_reg_t  cfg_index,
  input  logic [15:0]         cfg_data
);

  `include "motor_rail_fault_latch_unit_assert.svh"

  // configuration registers
  logic [15:0] settle_window_ms;
  logic [15:0] fault_debounce_ms;

  // latch and monitor state
  logic        trip_latch,        trip_latch_next;
  logic        estop_prev,        estop_prev_next;
  logic        enable_seen_prev,  enable_seen_prev_next;
  logic [31:0] enable_start_time, enable_start_time_next;
  logic [31:0] pgood_low_start,   pgood_low_start_next;
  logic        pgood_low_valid,   pgood_low_valid_next;

  logic               accept;
  logic               result_valid_next;
  mrfl_pkg::result_t  result_next;

  // step intermediates
  logic        latch_clr;
  logic        hold;
  logic        monitor_run;
  logic        mon_trip;
  logic [31:0] start_eff;
  logic [31:0] settle_elapsed;
  logic [31:0] low_start_eff;
  logic [31:0] low_elapsed;
  logic        trip;
  logic        latch_after;

  assign cfg_ready  = 1'b1;
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_window_ms  <= mrfl_pkg::SETTLE_WINDOW_RESET;
      fault_debounce_ms <= mrfl_pkg::FAULT_DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mrfl_pkg::CFG_SETTLE_WINDOW:  settle_window_ms  <= cfg_data;
        mrfl_pkg::CFG_FAULT_DEBOUNCE: fault_debounce_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // elapsed times, modular over the 32-bit timestamp
  assign start_eff      = enable_seen_prev ? enable_start_time : item.time_ms;
  assign settle_elapsed = item.time_ms - start_eff;
  assign low_start_eff  = pgood_low_valid ? pgood_low_start : item.time_ms;
  assign low_elapsed    = item.time_ms - low_start_eff;

  // step evaluation
  always_comb begin
    latch_clr   = trip_latch && !item.operator_clear;
    hold        = latch_clr && item.estop_active;
    monitor_run = !item.estop_active && item.system_powered;

    enable_seen_prev_next  = enable_seen_prev;
    enable_start_time_next = enable_start_time;
    pgood_low_start_next   = pgood_low_start;
    pgood_low_valid_next   = pgood_low_valid;
    mon_trip               = 1'b0;

    // power-good monitor, only while powered with no stop
    if (monitor_run) begin
      if (!item.motor_enabled_now) begin
        enable_seen_prev_next  = 1'b0;
        enable_start_time_next = '0;
        pgood_low_valid_next   = 1'b0;
      end else begin
        enable_seen_prev_next  = 1'b1;
        enable_start_time_next = start_eff;
        if (settle_elapsed >= {16'd0, settle_window_ms}) begin
          if (item.motor_power_good) begin
            pgood_low_valid_next = 1'b0;
          end else begin
            pgood_low_valid_next = 1'b1;
            pgood_low_start_next = low_start_eff;
            mon_trip             = low_elapsed >= {16'd0, fault_debounce_ms};
          end
        end
      end
    end

    trip        = item.estop_active || (monitor_run && mon_trip);
    latch_after = trip || latch_clr;
    // falling edge of the stop releases the latch
    if (estop_prev && !item.estop_active) begin
      latch_after = 1'b0;
    end

    result_next.motor_off_cmd = trip;
    result_next.fan_full_cmd  = trip;
    result_next.trip_cause    = item.estop_active ? mrfl_pkg::CAUSE_ESTOP :
                                (trip ? mrfl_pkg::CAUSE_PGOOD : mrfl_pkg::CAUSE_NONE);
    result_next.motor_on_cmd  = !latch_after && item.system_powered &&
                                !item.estop_active && !item.motor_enabled_now;
    result_next.trip_latched  = latch_after;
    trip_latch_next           = latch_after;
    estop_prev_next           = item.estop_active;

    // latched with no operator clear and stop still active: answer only, state held
    if (hold) begin
      result_next.motor_off_cmd = item.motor_enabled_now;
      result_next.fan_full_cmd  = 1'b0;
      result_next.trip_cause    = mrfl_pkg::CAUSE_NONE;
      result_next.motor_on_cmd  = 1'b0;
      result_next.trip_latched  = 1'b1;
      trip_latch_next           = 1'b1;
      estop_prev_next           = estop_prev;
      enable_seen_prev_next     = enable_seen_prev;
      enable_start_time_next    = enable_start_time;
      pgood_low_start_next      = pgood_low_start;
      pgood_low_valid_next      = pgood_low_valid;
    end
  end

  // output register occupancy
  always_comb begin
    if (accept) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      trip_latch        <= 1'b0;
      estop_prev        <= 1'b0;
      enable_seen_prev  <= 1'b0;
      enable_start_time <= '0;
      pgood_low_start   <= '0;
      pgood_low_valid   <= 1'b0;
      result_valid      <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
      if (accept) begin
        trip_latch        <= trip_latch_next;
        estop_prev        <= estop_prev_next;
        enable_seen_prev  <= enable_seen_prev_next;
        enable_start_time <= enable_start_time_next;
        pgood_low_start   <= pgood_low_start_next;
        pgood_low_valid   <= pgood_low_valid_next;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  // checks
  `MRFL_ASSERT_NOW(a_trip_drives_off, result_valid && (result.trip_cause != mrfl_pkg::CAUSE_NONE), result.motor_off_cmd && result.fan_full_cmd, "trip beat without off and fan commands")
  `MRFL_ASSERT_NOW(a_on_needs_clear, result_valid && result.motor_on_cmd, !result.trip_latched, "motor on commanded with latch set")
  `MRFL_ASSERT_NEXT(a_estop_latches, accept && item.estop_active && !hold, trip_latch && estop_prev, "stop beat did not set latch and stop history")
  `MRFL_ASSERT_NOW(a_low_needs_enable, pgood_low_valid, enable_seen_prev, "power-good low timer running without enable seen")
  `MRFL_ASSERT_NOW(a_start_cleared, !enable_seen_prev, enable_start_time == '0, "enable start time kept while disabled")

endmodule
